### design/perspective_point_projection_defines.svh
// assertion macros shared by the perspective projection design
`ifndef PERSPECTIVE_POINT_PROJECTION_DEFINES_SVH
`define PERSPECTIVE_POINT_PROJECTION_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PPP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppp same-cycle check failed");

// next-cycle implication, clocked on clk, off during reset
`define PPP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppp next-cycle check failed");

`endif

### design/ppp_pkg.sv
// package: widths, types and codes of the perspective projection design
package ppp_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int MAG_W       = COORD_WIDTH;
	localparam int F_W         = COORD_WIDTH - 1;
	localparam int PROD_W      = MAG_W + F_W;
	localparam int Q_W         = COORD_WIDTH;
	localparam int N_CELLS     = Q_W;
	localparam int CFG_IDX_W   = 2;

	localparam logic [F_W-1:0] FOCAL_RESET = F_W'(65536);
	localparam logic [COORD_WIDTH-1:0] CW_SIGN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic [COORD_WIDTH-1:0] CW_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAM_X  = 2'd0,
		REG_CAM_Y  = 2'd1,
		REG_CAM_H  = 2'd2,
		REG_FOCAL  = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_FRONT  = 2'd0,
		ST_BEHIND = 2'd1,
		ST_PLANE  = 2'd2
	} depth_status_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] cam_x;
		logic signed [COORD_WIDTH-1:0] cam_y;
		logic signed [COORD_WIDTH-1:0] cam_h;
		logic [F_W-1:0]                focal;
	} ppp_cfg_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] z;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] x;
	} ppp_point_t;

	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [Q_W-1:0]   nq;
	} ppp_div_t;

	typedef struct packed {
		logic          neg_x;
		logic          neg_z;
		logic          ovf_x;
		logic          ovf_z;
		depth_status_t status;
	} ppp_tag_t;

	typedef struct packed {
		ppp_div_t         x;
		ppp_div_t         z;
		logic [MAG_W-1:0] den;
		ppp_tag_t         tag;
	} ppp_work_t;

	typedef struct packed {
		logic [COORD_WIDTH-1:0] proj_y;
		logic [COORD_WIDTH-1:0] proj_x;
	} ppp_result_t;

endpackage

### design/ppp_front.sv
// front stages: camera offset, magnitudes times focal length, overflow check
module ppp_front import ppp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ppp_cfg_t   cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  ppp_point_t point,
	output logic       out_valid,
	input  logic       out_ready,
	output ppp_work_t  out_work
);

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [PROD_W-1:0]        px_s2, pz_s2;
	logic [MAG_W-1:0]         dmag_s2;
	ppp_tag_t                 tag_s2;
	ppp_work_t                work_s3;

	logic [DIFF_W-1:0] ax, ay, az;
	ppp_tag_t          tag_n;
	logic [MAG_W-1:0]  hx, hz;

	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready  = en1;
	assign out_valid = v_s3;
	assign out_work  = work_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// magnitudes and sign bookkeeping
	always_comb begin
		ax = dx_s1[DIFF_W-1] ? DIFF_W'(-dx_s1) : DIFF_W'(dx_s1);
		ay = dy_s1[DIFF_W-1] ? DIFF_W'(-dy_s1) : DIFF_W'(dy_s1);
		az = dz_s1[DIFF_W-1] ? DIFF_W'(-dz_s1) : DIFF_W'(dz_s1);
		tag_n.neg_x = dx_s1[DIFF_W-1] ^ dy_s1[DIFF_W-1];
		tag_n.neg_z = dz_s1[DIFF_W-1] ^ dy_s1[DIFF_W-1];
		tag_n.ovf_x = 1'b0;
		tag_n.ovf_z = 1'b0;
		if (dy_s1 == '0)
			tag_n.status = ST_PLANE;
		else if (dy_s1[DIFF_W-1])
			tag_n.status = ST_BEHIND;
		else
			tag_n.status = ST_FRONT;
	end

	// high part of the product seeds the remainder
	assign hx = MAG_W'(px_s2[PROD_W-1:Q_W]);
	assign hz = MAG_W'(pz_s2[PROD_W-1:Q_W]);

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			dx_s1 <= DIFF_W'(point.x) - DIFF_W'(cfg.cam_x);
			dy_s1 <= DIFF_W'(point.y) - DIFF_W'(cfg.cam_y);
			dz_s1 <= DIFF_W'(point.z) - DIFF_W'(cfg.cam_h);
		end
		if (en2) begin
			px_s2   <= PROD_W'(ax[MAG_W-1:0]) * PROD_W'(cfg.focal);
			pz_s2   <= PROD_W'(az[MAG_W-1:0]) * PROD_W'(cfg.focal);
			dmag_s2 <= ay[MAG_W-1:0];
			tag_s2  <= tag_n;
		end
		if (en3) begin
			work_s3.x.rem <= hx;
			work_s3.x.nq  <= px_s2[Q_W-1:0];
			work_s3.z.rem <= hz;
			work_s3.z.nq  <= pz_s2[Q_W-1:0];
			work_s3.den   <= dmag_s2;
			work_s3.tag   <= '{neg_x: tag_s2.neg_x, neg_z: tag_s2.neg_z,
				ovf_x: hx >= dmag_s2, ovf_z: hz >= dmag_s2, status: tag_s2.status};
		end
	end

endmodule

### design/ppp_div_cell.sv
// one restoring-division cell: one quotient bit per lane, both lanes share the divisor
module ppp_div_cell import ppp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ppp_work_t in_work,
	output logic      out_valid,
	input  logic      out_ready,
	output ppp_work_t out_work
);

	logic      v_q;
	ppp_work_t work_q;
	ppp_work_t work_n;
	logic      en;

	function automatic ppp_div_t div_step(ppp_div_t d, logic [MAG_W-1:0] den);
		logic [MAG_W:0] t;
		logic [MAG_W:0] diff;
		logic           ge;
		ppp_div_t       r;
		t    = {d.rem, d.nq[Q_W-1]};
		diff = t - {1'b0, den};
		ge   = t >= {1'b0, den};
		r.rem = ge ? diff[MAG_W-1:0] : t[MAG_W-1:0];
		r.nq  = {d.nq[Q_W-2:0], ge};
		return r;
	endfunction

	assign en        = !v_q || out_ready;
	assign in_ready  = en;
	assign out_valid = v_q;
	assign out_work  = work_q;

	always_comb begin
		work_n   = in_work;
		work_n.x = div_step(in_work.x, in_work.den);
		work_n.z = div_step(in_work.z, in_work.den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) work_q <= work_n;
	end

endmodule

### design/ppp_out.sv
// output stage: sign, saturation, camera-plane override, output register
module ppp_out import ppp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ppp_work_t     in_work,
	output logic          out_valid,
	input  logic          out_ready,
	output ppp_result_t   result,
	output depth_status_t status,
	output logic          sat
);

	logic          v_q;
	ppp_result_t   res_q;
	depth_status_t st_q;
	logic          sat_q;
	logic          en;

	logic [COORD_WIDTH-1:0] vx, vz;
	logic                   sx, sz;

	function automatic logic [COORD_WIDTH:0] clamp(logic [Q_W-1:0] q, logic neg, logic ovf);
		logic [COORD_WIDTH:0] r;
		if (neg) begin
			if (ovf || q > CW_SIGN) r = {1'b1, CW_SIGN};
			else r = {1'b0, COORD_WIDTH'(-q)};
		end else begin
			if (ovf || q[Q_W-1]) r = {1'b1, CW_MAX};
			else r = {1'b0, q};
		end
		return r;
	endfunction

	assign en        = !v_q || out_ready;
	assign in_ready  = en;
	assign out_valid = v_q;
	assign result    = res_q;
	assign status    = st_q;
	assign sat       = sat_q;

	always_comb begin
		{sx, vx} = clamp(in_work.x.nq, in_work.tag.neg_x, in_work.tag.ovf_x);
		{sz, vz} = clamp(in_work.z.nq, in_work.tag.neg_z, in_work.tag.ovf_z);
		if (in_work.tag.status == ST_PLANE) begin
			vx = '0;
			vz = '0;
			sx = 1'b0;
			sz = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			res_q.proj_x <= vx;
			res_q.proj_y <= vz;
			st_q         <= in_work.tag.status;
			sat_q        <= sx || sz;
		end
	end

endmodule

### design/perspective_point_projection.sv
// top level of the perspective projection divide block
//
// Usage:
//  - the slave stream carries one world point per beat; the master stream
//    returns one projected point per beat, in order
//  - the write port loads cam_x, cam_y, camera_height and focal_len; write
//    only while no beat is in flight
//  - a beat passes three front stages (offset, multiply by focal length,
//    overflow check), one row of 32 division cells each giving one quotient
//    bit, and the output register, which drives output tvalid
//  - while nothing stalls, throughput is one beat per cycle and every cell
//    hands its partial remainder and quotient to its neighbor each cycle
//  - each stage has its own valid bit and stalls only when the stage after
//    it is full, so input beats keep flowing into empty stages while the
//    receiver holds off tready
//  - reset clears all valid bits and loads the registers with zero camera
//    position and a focal length of 1.0
//  - a point on the camera plane returns zeros with status 2; results that
//    do not fit 32 bits clamp and raise the saturated bit
`include "perspective_point_projection_defines.svh"

module perspective_point_projection import ppp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [3*COORD_WIDTH-1:0] s_tdata,   // point_x, point_y, point_z
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [2*COORD_WIDTH-1:0] m_tdata,   // proj_x, proj_y
	output logic [2:0]               m_tuser,   // depth_status, saturated
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [COORD_WIDTH-1:0]   cfg_data
);

	ppp_cfg_t      cfg_q;
	ppp_work_t     work [N_CELLS+1];
	logic          vld  [N_CELLS+1];
	logic          rdy  [N_CELLS+1];
	ppp_result_t   result;
	depth_status_t status;
	logic          sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cam_x <= '0;
			cfg_q.cam_y <= '0;
			cfg_q.cam_h <= '0;
			cfg_q.focal <= FOCAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CAM_X: cfg_q.cam_x <= cfg_data;
				REG_CAM_Y: cfg_q.cam_y <= cfg_data;
				REG_CAM_H: cfg_q.cam_h <= cfg_data;
				REG_FOCAL: cfg_q.focal <= cfg_data[F_W-1:0];
				default: ;
			endcase
		end
	end

	ppp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.point     (ppp_point_t'(s_tdata)),
		.out_valid (vld[0]),
		.out_ready (rdy[0]),
		.out_work  (work[0])
	);

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		ppp_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[i]),
			.in_ready  (rdy[i]),
			.in_work   (work[i]),
			.out_valid (vld[i+1]),
			.out_ready (rdy[i+1]),
			.out_work  (work[i+1])
		);
	end

	ppp_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld[N_CELLS]),
		.in_ready  (rdy[N_CELLS]),
		.in_work   (work[N_CELLS]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result    (result),
		.status    (status),
		.sat       (sat)
	);

	assign m_tdata = result;
	assign m_tuser = {sat, status};

	`PPP_ASSERT_NOW(a_plane_zero, m_tvalid && status == ST_PLANE, result == '0 && !sat)
	`PPP_ASSERT_NOW(a_sat_clamped, m_tvalid && sat,
		result.proj_x == CW_MAX || result.proj_x == CW_SIGN ||
		result.proj_y == CW_MAX || result.proj_y == CW_SIGN)
	`PPP_ASSERT_NEXT(a_cfg_focal, cfg_we && cfg_reg_t'(cfg_index) == REG_FOCAL,
		cfg_q.focal == $past(cfg_data[F_W-1:0]))

endmodule

### verif/tb.sv
// testbench for perspective_point_projection: predicted projections checked beat by beat
`timescale 1ns / 1ps

module tb import ppp_pkg::*; ();

	localparam logic [31:0] C_MIN    = CW_SIGN;
	localparam logic [31:0] C_MAX    = CW_MAX;
	localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
	localparam int          SETTLE   = 40;
	localparam int          PHASES   = 8;
	localparam int          PHASE_SZ = 60;

	typedef struct {
		logic [31:0]   px;
		logic [31:0]   py;
		depth_status_t st;
		logic          sat;
	} proj_expect_t;

	typedef enum {RX_OPEN, RX_COIN, RX_CHOKE, RX_RHYTHM} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [95:0]          s_tdata = '0;   // point_x, point_y, point_z
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [63:0]          m_tdata;        // proj_x, proj_y
	logic [2:0]           m_tuser;        // depth_status, saturated
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	logic signed [31:0] cam_x_r = '0;
	logic signed [31:0] cam_y_r = '0;
	logic signed [31:0] cam_h_r = '0;
	logic [F_W-1:0]     focal_r = FOCAL_RESET;

	proj_expect_t proj_q[$];
	proj_expect_t due;
	int           fail_count = 0;
	int           burst_left = 0;
	bit           idle_on = 1'b1;
	rx_mode_t     rx_mode = RX_OPEN;
	int           rx_left = 0;
	int           rx_tick = 0;

	perspective_point_projection DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] scaled_quotient(input longint num, input longint den,
			input logic [F_W-1:0] f, output logic clamp);
		logic [63:0] mn;
		logic [63:0] md;
		logic [63:0] q;
		logic        neg;
		clamp = 1'b0;
		mn = (num < 0) ? 64'(-num) : 64'(num);
		md = (den < 0) ? 64'(-den) : 64'(den);
		q = (mn * {33'd0, f}) / md;
		neg = (num < 0) != (den < 0);
		if (q == 64'd0)
			return '0;
		if (neg) begin
			if (q > 64'h8000_0000) begin
				clamp = 1'b1;
				q = 64'h8000_0000;
			end
			return 32'(64'd0 - q);
		end
		if (q > 64'h7FFF_FFFF) begin
			clamp = 1'b1;
			q = 64'h7FFF_FFFF;
		end
		return q[31:0];
	endfunction

	function automatic proj_expect_t project_point(input ppp_point_t p);
		longint       dx;
		longint       dy;
		longint       dz;
		logic         cx;
		logic         cz;
		proj_expect_t r;
		dx = longint'(p.x) - longint'(cam_x_r);
		dy = longint'(p.y) - longint'(cam_y_r);
		dz = longint'(p.z) - longint'(cam_h_r);
		if (dy == 0) begin
			r.px = '0;
			r.py = '0;
			r.st = ST_PLANE;
			r.sat = 1'b0;
			return r;
		end
		r.px = scaled_quotient(dx, dy, focal_r, cx);
		r.py = scaled_quotient(dz, dy, focal_r, cz);
		r.st = (dy > 0) ? ST_FRONT : ST_BEHIND;
		r.sat = cx | cz;
		return r;
	endfunction

	function automatic ppp_point_t pt(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		ppp_point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		return p;
	endfunction

	function automatic logic [31:0] near(input logic [31:0] base, input int span);
		return base + 32'($urandom_range(0, 2 * span)) - 32'(span);
	endfunction

	function automatic logic [31:0] edge_value();
		case ($urandom_range(0, 4))
			0: return C_MIN;
			1: return C_MAX;
			2: return 32'd0;
			3: return 32'hFFFF_FFFF;
			default: return 32'd1;
		endcase
	endfunction

	function automatic ppp_point_t pick_point();
		ppp_point_t p;
		p = pt($urandom, $urandom, $urandom);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: p = pt(near(cam_x_r, 1 << 22), near(cam_y_r, 1 << 20),
				near(cam_h_r, 1 << 22));
			4: p.y = cam_y_r;
			5: p = pt(near(cam_x_r, 1 << 22), cam_y_r - 32'($urandom_range(1, 1 << 20)),
				near(cam_h_r, 1 << 22));
			6: p = pt(edge_value(), edge_value(), edge_value());
			7: p = pt(near(cam_x_r, 1 << 26), near(cam_y_r, 4), near(cam_h_r, 1 << 26));
			default: ;
		endcase
		return p;
	endfunction

	// receiver hold-off
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN: m_tready = 1'b1;
			RX_COIN: m_tready = 1'($urandom_range(0, 1));
			RX_CHOKE: m_tready = ($urandom_range(0, 3) == 0);
			default: m_tready = (rx_tick % 7) > 2;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (proj_q.size() == 0) begin
				$display("%0t: beat with nothing expected, got data %h user %h",
					$time, m_tdata, m_tuser);
				fail_count++;
			end else begin
				due = proj_q.pop_front();
				if (m_tdata[31:0] !== due.px) begin
					$display("%0t: proj_x expected %h got %h", $time, due.px, m_tdata[31:0]);
					fail_count++;
				end
				if (m_tdata[63:32] !== due.py) begin
					$display("%0t: proj_y expected %h got %h", $time, due.py, m_tdata[63:32]);
					fail_count++;
				end
				if (m_tuser[1:0] !== due.st) begin
					$display("%0t: depth_status expected %0d got %0d", $time, due.st,
						m_tuser[1:0]);
					fail_count++;
				end
				if (m_tuser[2] !== due.sat) begin
					$display("%0t: saturated expected %b got %b", $time, due.sat, m_tuser[2]);
					fail_count++;
				end
			end
		end
	end

	task automatic send_point(input ppp_point_t p);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (idle_on)
				repeat ($urandom_range(0, 7) == 0 ? 20 : $urandom_range(1, 6)) @(negedge clk);
		end
		s_tdata = p;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		proj_q.push_back(project_point(p));
		burst_left--;
		@(negedge clk);
		if (idle_on && burst_left == 0)
			s_tvalid = 1'b0;
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		burst_left = 0;
		while (proj_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			REG_CAM_X: cam_x_r = val;
			REG_CAM_Y: cam_y_r = val;
			REG_CAM_H: cam_h_r = val;
			default: focal_r = val[F_W-1:0];
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_camera(input logic [31:0] x, input logic [31:0] y, input logic [31:0] h,
			input logic [31:0] f);
		settle();
		write_reg(REG_CAM_X, x);
		write_reg(REG_CAM_Y, y);
		write_reg(REG_CAM_H, h);
		write_reg(REG_FOCAL, f);
	endtask

	task automatic test_defaults();
		send_point(pt(32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
		send_point(pt(32'hFFFB_0000, 32'h0004_0000, 32'h0007_8000));
		send_point(pt(32'h0009_0000, 32'd0, 32'h0009_0000));
		send_point(pt(32'h0003_0000, 32'hFFFE_0000, 32'hFFFF_0000));
		send_point(pt(32'd0, 32'd1, 32'd0));
		send_point(pt(C_MAX, 32'd1, C_MIN));
	endtask

	// quotients right at and just past the clamp points
	task automatic test_clamp_edges();
		set_camera(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1);
		send_point(pt(C_MAX, 32'd1, C_MIN));
		send_point(pt(32'hFFFF_FFFE, 32'd1, C_MIN));
		send_point(pt(C_MAX - 32'd1, 32'd1, 32'd0));
		send_point(pt(32'hFFFF_FFFE, 32'hFFFF_FFFF, C_MAX));
		send_point(pt(C_MIN, 32'hFFFF_FFFF, C_MIN + 32'd1));
	endtask

	task automatic test_camera_extremes();
		set_camera(C_MIN, C_MAX, C_MIN, 32'hFFFF_FFFF);
		send_point(pt(C_MAX, C_MIN, C_MAX));
		send_point(pt(C_MIN, C_MAX, C_MIN));
		send_point(pt(32'd0, 32'd0, 32'd0));
		send_point(pt(32'd5, C_MAX - 32'd1, 32'hFFFF_FFF0));
		set_camera(C_MAX, C_MIN, C_MAX, 32'd0);
		send_point(pt(C_MIN, C_MAX, C_MIN));
		send_point(pt(C_MAX, C_MIN + 32'd1, 32'd0));
		settle();
		write_reg(REG_FOCAL, ONE_Q16);
		send_point(pt(C_MIN, C_MIN + 32'd1, C_MIN));
	endtask

	task automatic test_random_phases();
		logic [31:0] f;
		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0: f = $urandom;
				1: f = $urandom_range(1 << 12, 1 << 24);
				2: f = ONE_Q16;
				default: f = $urandom_range(0, 8);
			endcase
			if (ph == 0)
				set_camera(C_MIN, C_MIN, C_MIN, 32'hFFFF_FFFF);
			else if (ph == 1)
				set_camera(C_MAX, C_MAX, C_MAX, ONE_Q16);
			else if ($urandom_range(0, 1))
				set_camera($urandom, $urandom, $urandom, f);
			else
				set_camera(near(0, 1 << 24), near(0, 1 << 24), near(0, 1 << 24), f);
			idle_on = !(ph == 2 || ph == 5);
			for (int i = 0; i < PHASE_SZ; i++)
				send_point(pick_point());
		end
		idle_on = 1'b1;
	endtask

	initial begin
		#2_000_000;
		$display("** perspective_point_projection: FAILED **");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_defaults();
		test_clamp_edges();
		test_camera_extremes();
		test_random_phases();
		settle();
		if (fail_count == 0)
			$display("** perspective_point_projection: PASSED **");
		else
			$display("** perspective_point_projection: FAILED **");
		$finish;
	end

endmodule
